// ----- rtl/bhal_pkg.sv -----
`timescale 1ns / 1ps

package bhal_pkg;

	localparam int HANDLE_W        = 8;
	localparam int WORD_W          = 32;
	localparam int LIMIT_W         = 9;
	localparam int MODE_W          = 2;
	localparam int STATUS_W        = 2;
	localparam int TDATA_W         = 40;
	localparam int CHUNK_W         = 32;
	localparam int CHUNK_SH        = 5;
	localparam int MAX_HANDLES_DEF = 256;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

	typedef enum logic [MODE_W-1:0] {
		MODE_ALLOC   = 2'd0,
		MODE_LOOKUP  = 2'd1,
		MODE_RELEASE = 2'd2,
		MODE_NOP     = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_RANGE = 2'd2,
		STAT_IDLE  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_SCAN,
		SEQ_ACCESS,
		SEQ_READ,
		SEQ_PUSH
	} seq_state_t;

	typedef struct packed {
		status_t             status;
		logic [HANDLE_W-1:0] granted_handle;
		logic [WORD_W-1:0]   stored_word;
	} result_t;

	typedef struct packed {
		logic                found;
		logic [CHUNK_SH-1:0] idx;
	} pick_t;

	// Lowest set bit of a chunk.
	function automatic pick_t pick_lowest(input logic [CHUNK_W-1:0] v);
		pick_t p;
		p = '0;
		for (int j = CHUNK_W - 1; j >= 0; j--) begin
			if (v[j]) begin
				p.found = 1'b1;
				p.idx   = CHUNK_SH'(j);
			end
		end
		return p;
	endfunction

	// Bits of a chunk that lie below the limit, given the limit minus the chunk base.
	function automatic logic [CHUNK_W-1:0] chunk_mask(input logic [LIMIT_W-1:0] rem);
		logic [CHUNK_W-1:0] m;
		for (int j = 0; j < CHUNK_W; j++) begin
			m[j] = (LIMIT_W'(j) < rem);
		end
		return m;
	endfunction

endpackage

// ----- rtl/bhal_bitmap.sv -----
`timescale 1ns / 1ps

module bhal_bitmap #(
	parameter int NCHUNK = 8,
	parameter int CIW    = 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clr,
	input  logic [CIW-1:0]                idx,
	input  logic                          we,
	input  logic [bhal_pkg::CHUNK_W-1:0]  wdata,
	output logic [bhal_pkg::CHUNK_W-1:0]  rdata
);

	logic [bhal_pkg::CHUNK_W-1:0] bits_q [NCHUNK];
	logic                         idx_ok;

	assign idx_ok = ({1'b0, idx} < (CIW + 1)'(NCHUNK));
	assign rdata  = idx_ok ? bits_q[idx] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCHUNK; i++) begin
				bits_q[i] <= '0;
			end
		end else if (clr) begin
			for (int i = 0; i < NCHUNK; i++) begin
				bits_q[i] <= '0;
			end
		end else if (we && idx_ok) begin
			bits_q[idx] <= wdata;
		end
	end

endmodule

// ----- rtl/bhal_word_ram.sv -----
`timescale 1ns / 1ps

module bhal_word_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [AW-1:0]                waddr,
	input  logic [bhal_pkg::WORD_W-1:0]  wdata,
	input  logic                         re,
	input  logic [AW-1:0]                raddr,
	output logic [bhal_pkg::WORD_W-1:0]  rdata_q
);

	logic [bhal_pkg::WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

// ----- rtl/bhal_ctrl.sv -----
`timescale 1ns / 1ps

module bhal_ctrl #(
	parameter int CIW         = 3,
	parameter int AW          = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [bhal_pkg::MODE_W-1:0]     in_mode,
	input  logic [bhal_pkg::HANDLE_W-1:0]   in_handle,
	input  logic [bhal_pkg::WORD_W-1:0]     in_word,
	input  logic [bhal_pkg::LIMIT_W-1:0]    lim,
	output logic [CIW-1:0]                  bm_idx,
	input  logic [bhal_pkg::CHUNK_W-1:0]    bm_rdata,
	output logic                            bm_we,
	output logic [bhal_pkg::CHUNK_W-1:0]    bm_wdata,
	output logic                            ram_we,
	output logic [AW-1:0]                   ram_waddr,
	output logic [bhal_pkg::WORD_W-1:0]     ram_wdata,
	output logic                            ram_re,
	output logic [AW-1:0]                   ram_raddr,
	input  logic [bhal_pkg::WORD_W-1:0]     ram_rdata,
	output logic                            res_valid,
	input  logic                            res_ready,
	output bhal_pkg::result_t               res
);

	localparam int LW = bhal_pkg::LIMIT_W;
	localparam int CW = bhal_pkg::CHUNK_W;

	bhal_pkg::seq_state_t          state_q, state_d;
	bhal_pkg::mode_t               mode_q;
	logic [bhal_pkg::HANDLE_W-1:0] handle_q;
	logic [bhal_pkg::WORD_W-1:0]   word_q;
	logic [CIW-1:0]                scan_q, scan_d;
	bhal_pkg::result_t             res_q, res_d;

	logic [LW-1:0]      hx;
	logic [CIW-1:0]     h_chunk;
	logic               in_range;
	logic               bit_sel;
	logic [LW-1:0]      base;
	logic [LW-1:0]      rem;
	logic [CW-1:0]      free_vec;
	bhal_pkg::pick_t    pick;
	logic               last_chunk;
	logic [LW-1:0]      grant;
	logic               accept;

	assign hx         = {1'b0, handle_q};
	assign h_chunk    = hx[bhal_pkg::CHUNK_SH +: CIW];
	assign in_range   = (hx < lim);
	assign bit_sel    = bm_rdata[handle_q[bhal_pkg::CHUNK_SH-1:0]];
	assign base       = LW'({scan_q, {bhal_pkg::CHUNK_SH{1'b0}}});
	assign rem        = lim - base;
	assign free_vec   = ~bm_rdata & bhal_pkg::chunk_mask(rem);
	assign pick       = bhal_pkg::pick_lowest(free_vec);
	assign last_chunk = (({1'b0, base} + (LW + 1)'(CW)) >= {1'b0, lim});
	assign grant      = LW'({scan_q, pick.idx});
	assign accept     = in_valid && in_ready;
	assign res        = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bhal_pkg::SEQ_IDLE;
			scan_q  <= '0;
		end else begin
			state_q <= state_d;
			scan_q  <= scan_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= bhal_pkg::mode_t'(in_mode);
			handle_q <= in_handle;
			word_q   <= in_word;
		end
		res_q <= res_d;
	end

	always_comb begin
		state_d   = state_q;
		scan_d    = scan_q;
		res_d     = res_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		bm_idx    = h_chunk;
		bm_we     = 1'b0;
		bm_wdata  = bm_rdata;
		ram_we    = 1'b0;
		ram_waddr = grant[AW-1:0];
		ram_wdata = word_q;
		ram_re    = 1'b0;
		ram_raddr = handle_q[AW-1:0];
		case (state_q)
			bhal_pkg::SEQ_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					scan_d = '0;
					case (bhal_pkg::mode_t'(in_mode))
						bhal_pkg::MODE_ALLOC: begin
							state_d = bhal_pkg::SEQ_SCAN;
						end
						bhal_pkg::MODE_LOOKUP, bhal_pkg::MODE_RELEASE: begin
							state_d = bhal_pkg::SEQ_ACCESS;
						end
						default: begin
							res_d   = '{bhal_pkg::STAT_OK, '0, '0};
							state_d = bhal_pkg::SEQ_PUSH;
						end
					endcase
				end
			end
			bhal_pkg::SEQ_SCAN: begin
				bm_idx = scan_q;
				if (pick.found) begin
					bm_we    = 1'b1;
					bm_wdata = bm_rdata | (CW'(1) << pick.idx);
					ram_we   = 1'b1;
					res_d    = '{bhal_pkg::STAT_OK, grant[bhal_pkg::HANDLE_W-1:0], '0};
					state_d  = bhal_pkg::SEQ_PUSH;
				end else if (last_chunk) begin
					res_d   = '{bhal_pkg::STAT_FULL, '0, '0};
					state_d = bhal_pkg::SEQ_PUSH;
				end else begin
					scan_d = scan_q + CIW'(1);
				end
			end
			bhal_pkg::SEQ_ACCESS: begin
				state_d = bhal_pkg::SEQ_PUSH;
				if (!in_range) begin
					res_d = '{bhal_pkg::STAT_RANGE, '0, '0};
				end else if (mode_q == bhal_pkg::MODE_LOOKUP) begin
					// A handle not in use has a zero word by definition.
					res_d = '{bhal_pkg::STAT_OK, '0, '0};
					if (bit_sel) begin
						ram_re  = 1'b1;
						state_d = bhal_pkg::SEQ_READ;
					end
				end else if (!bit_sel) begin
					res_d = '{bhal_pkg::STAT_IDLE, '0, '0};
				end else begin
					bm_we    = 1'b1;
					bm_wdata = bm_rdata & ~(CW'(1) << handle_q[bhal_pkg::CHUNK_SH-1:0]);
					res_d    = '{bhal_pkg::STAT_OK, '0, '0};
				end
			end
			bhal_pkg::SEQ_READ: begin
				res_d   = '{bhal_pkg::STAT_OK, '0, ram_rdata};
				state_d = bhal_pkg::SEQ_PUSH;
			end
			bhal_pkg::SEQ_PUSH: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = bhal_pkg::SEQ_IDLE;
				end
			end
			default: begin
				state_d = bhal_pkg::SEQ_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/bitmap_handle_allocator_core.sv -----
`timescale 1ns / 1ps
// Path, accept to m_tvalid: allocate scans the in-use bitmap from chunk 0, one 32-bit
// chunk per cycle, until a free bit or the last chunk below the effective limit; lookup of
// a used handle passes ACCESS and READ, other lookups and release pass ACCESS, mode three
// goes straight to PUSH; the result waits in PUSH while the output register stays full.
// Throughput: one word at a time; the next word is taken after the result has left PUSH.
// Reset: asynchronous, active low; limit returns to 256, every handle is free.

module bitmap_handle_allocator_core #(
	parameter int MAX_HANDLES = bhal_pkg::MAX_HANDLES_DEF // 8..256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input words
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [bhal_pkg::TDATA_W-1:0]   s_tdata,  // [7:0] handle, [39:8] private_word
	input  logic [bhal_pkg::MODE_W-1:0]    s_tuser,  // [1:0] mode
	// result words
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [bhal_pkg::TDATA_W-1:0]   m_tdata,  // [7:0] granted_handle, [39:8] stored_word
	output logic [bhal_pkg::STATUS_W-1:0]  m_tuser,  // [1:0] status
	// limit register write
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bhal_pkg::LIMIT_W-1:0]   cfg_data
);

	localparam int NCHUNK = (MAX_HANDLES + bhal_pkg::CHUNK_W - 1) / bhal_pkg::CHUNK_W;
	localparam int CIW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
	localparam int AW     = (MAX_HANDLES > 1) ? $clog2(MAX_HANDLES) : 1;
	localparam logic [bhal_pkg::LIMIT_W-1:0] LIM_CAP = bhal_pkg::LIMIT_W'(MAX_HANDLES);

	logic [bhal_pkg::LIMIT_W-1:0] limit_q;
	logic [bhal_pkg::LIMIT_W-1:0] lim_round;
	logic [bhal_pkg::LIMIT_W-1:0] lim_eff;
	logic                         cfg_wr;

	logic [CIW-1:0]                bm_idx;
	logic [bhal_pkg::CHUNK_W-1:0]  bm_rdata;
	logic                          bm_we;
	logic [bhal_pkg::CHUNK_W-1:0]  bm_wdata;
	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr;
	logic [bhal_pkg::WORD_W-1:0]   ram_wdata;
	logic                          ram_re;
	logic [AW-1:0]                 ram_raddr;
	logic [bhal_pkg::WORD_W-1:0]   ram_rdata;

	logic                          res_valid;
	logic                          res_ready;
	bhal_pkg::result_t             res;
	logic                          m_tvalid_q;
	bhal_pkg::result_t             out_q;

	// Effective limit: round down to a multiple of eight, then saturate at MAX_HANDLES.
	assign lim_round = {limit_q[bhal_pkg::LIMIT_W-1:3], 3'b000};
	assign lim_eff   = (lim_round > LIM_CAP) ? LIM_CAP : lim_round;

	// Limit writes are taken only between words; a write frees every handle.
	assign cfg_ready = s_tready;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= bhal_pkg::LIMIT_RESET;
		end else if (cfg_wr) begin
			limit_q <= cfg_data;
		end
	end

	// Sequencer: scans the bitmap one chunk per cycle for allocate, probes one bit for
	// lookup and release.
	bhal_ctrl #(
		.CIW         (CIW),
		.AW          (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_mode   (s_tuser),
		.in_handle (s_tdata[bhal_pkg::HANDLE_W-1:0]),
		.in_word   (s_tdata[bhal_pkg::HANDLE_W +: bhal_pkg::WORD_W]),
		.lim       (lim_eff),
		.bm_idx    (bm_idx),
		.bm_rdata  (bm_rdata),
		.bm_we     (bm_we),
		.bm_wdata  (bm_wdata),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// In-use bitmap in flops, cleared at once by reset or a limit write.
	bhal_bitmap #(
		.NCHUNK (NCHUNK),
		.CIW    (CIW)
	) u_bitmap (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (cfg_wr),
		.idx    (bm_idx),
		.we     (bm_we),
		.wdata  (bm_wdata),
		.rdata  (bm_rdata)
	);

	// Private words. Never cleared: a word is only read back while its in-use bit is set,
	// and a free handle reads as zero.
	bhal_word_ram #(
		.DEPTH (MAX_HANDLES),
		.AW    (AW)
	) u_word_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.re      (ram_re),
		.raddr   (ram_raddr),
		.rdata_q (ram_rdata)
	);

	// Output register: hold the result until the sink takes it.
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_q.stored_word, out_q.granted_handle};
	assign m_tuser  = out_q.status;

endmodule

// ----- dv/handle_alloc_checker.sv -----
`timescale 1ns / 1ps

// Watches the request, result and limit channels, keeps shadow copies of the in-use bitmap
// and the private word table, and compares every result word with the oldest prediction.
module handle_alloc_checker #(
	parameter int MAX_HANDLES = bhal_pkg::MAX_HANDLES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [bhal_pkg::TDATA_W-1:0]   s_tdata,  // [7:0] handle, [39:8] private_word
	input  logic [bhal_pkg::MODE_W-1:0]    s_tuser,  // [1:0] mode
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [bhal_pkg::TDATA_W-1:0]   m_tdata,  // [7:0] granted_handle, [39:8] stored_word
	input  logic [bhal_pkg::STATUS_W-1:0]  m_tuser,  // [1:0] status
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [bhal_pkg::LIMIT_W-1:0]   cfg_data,
	output int                             outstanding,
	output int                             fail_count,
	output int                             full_seen,
	output int                             range_seen,
	output int                             idle_seen
);

	localparam int HW = bhal_pkg::HANDLE_W;
	localparam int WW = bhal_pkg::WORD_W;
	localparam int DW = bhal_pkg::TDATA_W;

	logic [bhal_pkg::LIMIT_W-1:0]  limit_reg;
	bit                            in_use [MAX_HANDLES];
	logic [WW-1:0]                 word_tab [MAX_HANDLES];
	bhal_pkg::result_t             pending_answers [$];

	function automatic int usable_handles();
		int n;
		n = int'(limit_reg) & ~7;
		if (n > MAX_HANDLES) begin
			n = MAX_HANDLES;
		end
		return n;
	endfunction

	function automatic void clear_tables();
		for (int i = 0; i < MAX_HANDLES; i++) begin
			in_use[i]   = 1'b0;
			word_tab[i] = '0;
		end
	endfunction

	// Apply one request to the shadow tables and return the answer it must produce.
	function automatic bhal_pkg::result_t serve_request(input bhal_pkg::mode_t mode,
			input logic [HW-1:0] h, input logic [WW-1:0] w);
		bhal_pkg::result_t r;
		int                lim;
		r        = '0;
		r.status = bhal_pkg::STAT_OK;
		lim      = usable_handles();
		case (mode)
			bhal_pkg::MODE_ALLOC: begin
				r.status = bhal_pkg::STAT_FULL;
				for (int i = 0; i < lim; i++) begin
					if (!in_use[i] && r.status == bhal_pkg::STAT_FULL) begin
						in_use[i]        = 1'b1;
						word_tab[i]      = w;
						r.granted_handle = HW'(i);
						r.status         = bhal_pkg::STAT_OK;
					end
				end
			end
			bhal_pkg::MODE_LOOKUP: begin
				if (int'(h) >= lim) begin
					r.status = bhal_pkg::STAT_RANGE;
				end else begin
					r.stored_word = word_tab[h];
				end
			end
			bhal_pkg::MODE_RELEASE: begin
				if (int'(h) >= lim) begin
					r.status = bhal_pkg::STAT_RANGE;
				end else if (!in_use[h]) begin
					r.status = bhal_pkg::STAT_IDLE;
				end else begin
					in_use[h]   = 1'b0;
					word_tab[h] = '0;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [WW-1:0] want,
			input logic [WW-1:0] got);
		fail_count++;
		$display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		bhal_pkg::result_t want;
		if (!arst_n) begin
			limit_reg = bhal_pkg::LIMIT_RESET;
			clear_tables();
			pending_answers.delete();
			fail_count = 0;
			full_seen  = 0;
			range_seen = 0;
			idle_seen  = 0;
		end else begin
			// retire the result first: it can never belong to a word accepted at this edge
			if (m_tvalid && m_tready) begin
				case (bhal_pkg::status_t'(m_tuser))
					bhal_pkg::STAT_FULL:  full_seen++;
					bhal_pkg::STAT_RANGE: range_seen++;
					bhal_pkg::STAT_IDLE:  idle_seen++;
					default: begin
					end
				endcase
				if (pending_answers.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result word, expected none, got status %0d data %h",
						$time, m_tuser, m_tdata);
				end else begin
					want = pending_answers.pop_front();
					if (m_tuser !== want.status) begin
						report_mismatch("status", WW'(want.status), WW'(m_tuser));
					end
					if (m_tdata[HW-1:0] !== want.granted_handle) begin
						report_mismatch("granted_handle", WW'(want.granted_handle),
							WW'(m_tdata[HW-1:0]));
					end
					if (m_tdata[DW-1:HW] !== want.stored_word) begin
						report_mismatch("stored_word", want.stored_word, m_tdata[DW-1:HW]);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				limit_reg = cfg_data;
				clear_tables();
			end
			if (s_tvalid && s_tready) begin
				pending_answers.push_back(serve_request(bhal_pkg::mode_t'(s_tuser),
					s_tdata[HW-1:0], s_tdata[DW-1:HW]));
			end
		end
		outstanding = pending_answers.size();
	end

endmodule

// ----- dv/bitmap_handle_allocator_core_test.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the handle allocator. Requests are driven on the falling edge,
// everything is sampled on the rising edge; handle_alloc_checker does the prediction.
module bitmap_handle_allocator_core_test;

	// Longest legal quiet stretch: sender gap, a full allocate scan, receiver stall and the
	// pause before a limit write. Take a wide margin.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int N_PHASES       = 10;
	localparam int HW             = bhal_pkg::HANDLE_W;
	localparam int WW             = bhal_pkg::WORD_W;
	localparam int LW             = bhal_pkg::LIMIT_W;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [bhal_pkg::TDATA_W-1:0]    s_tdata;   // [7:0] handle, [39:8] private_word
	logic [bhal_pkg::MODE_W-1:0]     s_tuser;   // [1:0] mode
	logic                            m_tvalid;
	logic                            m_tready;
	logic [bhal_pkg::TDATA_W-1:0]    m_tdata;   // [7:0] granted_handle, [39:8] stored_word
	logic [bhal_pkg::STATUS_W-1:0]   m_tuser;   // [1:0] status
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [LW-1:0]                   cfg_data;

	int outstanding;
	int fail_count;
	int full_seen;
	int range_seen;
	int idle_seen;

	int  words_sent;
	int  limits_written;
	int  quiet_cycles;
	bit  src_burst;
	bit  sink_burst;
	int  sink_stall;

	always #2 clk = ~clk;

	bitmap_handle_allocator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	handle_alloc_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.outstanding (outstanding),
		.fail_count  (fail_count),
		.full_seen   (full_seen),
		.range_seen  (range_seen),
		.idle_seen   (idle_seen)
	);

	// Offer one request word and hold it until accepted. Entered and left at a falling
	// edge; s_tvalid stays high on return so back-to-back words need no dip.
	task automatic put_request(input bhal_pkg::mode_t mode, input logic [HW-1:0] h,
			input logic [WW-1:0] w);
		int gap;
		gap = src_burst ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = mode;
		s_tdata  = {w, h};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		words_sent++;
	endtask

	// Stop offering words until every prediction has been answered.
	task automatic drain();
		s_tvalid = 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	// Write handle_limit only while the block is idle; leave a scan's worth of cycles first.
	task automatic write_limit(input logic [LW-1:0] v);
		drain();
		repeat (12) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		limits_written++;
	endtask

	function automatic int usable_for(input logic [LW-1:0] v);
		int n;
		n = int'(v) & ~7;
		return (n > bhal_pkg::MAX_HANDLES_DEF) ? bhal_pkg::MAX_HANDLES_DEF : n;
	endfunction

	// Receiver: after each taken result word, drop m_tready for a random stall; occasional no-stall runs.
	initial begin
		m_tready   = 1'b0;
		sink_stall = 0;
		sink_burst = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_stall > 0 || !arst_n) begin
				m_tready = 1'b0;
				if (sink_stall > 0) begin
					sink_stall--;
				end
			end else begin
				m_tready = 1'b1;
			end
			@(posedge clk);
			if (m_tready && m_tvalid) begin
				if ($urandom_range(0, 29) == 0) begin
					sink_burst = !sink_burst;
				end
				sink_stall = sink_burst ? 0 : $urandom_range(0, 15);
			end
		end
	end

	// Watchdog: any accepted word on any channel resets the quiet count.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("bitmap_handle_allocator_core test failed");
			$finish;
		end
	end

	initial begin
		logic [LW-1:0]    phase_limit;
		int               phase_len;
		int               lim;
		int               fill_len;
		int               seg_left;
		int               alloc_pct;
		int               pick;
		bhal_pkg::mode_t  mode;
		logic [HW-1:0]    h;
		logic [WW-1:0]    w;

		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = bhal_pkg::MODE_ALLOC;
		cfg_valid      = 1'b0;
		cfg_data       = '0;
		words_sent     = 0;
		limits_written = 0;
		quiet_cycles   = 0;
		src_burst      = 1'b0;
		seg_left       = 0;
		alloc_pct      = 50;

		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed, reset limit of 256: empty table, lowest-first grants, reuse of a
		// released handle, lookup of a valid free handle, release of a free handle, mode three.
		put_request(bhal_pkg::MODE_LOOKUP, 8'h00, 32'hFFFF_FFFF);
		put_request(bhal_pkg::MODE_RELEASE, 8'h00, 32'h0);
		put_request(bhal_pkg::MODE_ALLOC, 8'hFF, 32'hFFFF_FFFF);
		put_request(bhal_pkg::MODE_ALLOC, 8'h00, 32'h0000_0000);
		put_request(bhal_pkg::MODE_ALLOC, 8'h5A, 32'hA5A5_A5A5);
		put_request(bhal_pkg::MODE_LOOKUP, 8'h00, 32'h0);
		put_request(bhal_pkg::MODE_LOOKUP, 8'hFF, 32'h0);
		put_request(bhal_pkg::MODE_RELEASE, 8'hFF, 32'h0);
		put_request(bhal_pkg::MODE_RELEASE, 8'h01, 32'h0);
		put_request(bhal_pkg::MODE_LOOKUP, 8'h01, 32'h0);
		put_request(bhal_pkg::MODE_ALLOC, 8'h00, 32'h5A5A_5A5A);
		put_request(bhal_pkg::MODE_NOP, 8'hFF, 32'hFFFF_FFFF);

		// Smallest usable limit: fill all eight, run out, then probe just past the top.
		write_limit(9'd8);
		for (int i = 0; i < 9; i++) begin
			put_request(bhal_pkg::MODE_ALLOC, HW'($urandom), 32'h1000_0000 + i);
		end
		put_request(bhal_pkg::MODE_LOOKUP, 8'h08, 32'h0);
		put_request(bhal_pkg::MODE_RELEASE, 8'hFF, 32'h0);
		put_request(bhal_pkg::MODE_LOOKUP, 8'h07, 32'h0);

		// Limit below eight rounds down to no handles at all.
		write_limit(9'd7);
		put_request(bhal_pkg::MODE_ALLOC, 8'h00, 32'hDEAD_BEEF);
		put_request(bhal_pkg::MODE_RELEASE, 8'h00, 32'h0);

		// Random phases: each opens with a fill-heavy stretch long enough to exhaust the table, then
		// switches at random among allocate-heavy, balanced and release-heavy segments.
		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
				0:       begin phase_limit = 9'd511; phase_len = 420; end
				1:       begin phase_limit = 9'd24;  phase_len = 150; end
				2:       begin phase_limit = 9'd0;   phase_len = 30;  end
				3:       begin phase_limit = 9'd256; phase_len = 300; end
				4:       begin phase_limit = 9'd7;   phase_len = 30;  end
				5:       begin phase_limit = 9'd64;  phase_len = 200; end
				6:       begin phase_limit = 9'd13;  phase_len = 120; end
				7:       begin phase_limit = 9'd300; phase_len = 150; end
				8:       begin phase_limit = 9'd8;   phase_len = 120; end
				default: begin phase_limit = 9'd100; phase_len = 150; end
			endcase
			write_limit(phase_limit);
			lim      = usable_for(phase_limit);
			fill_len = lim + lim / 8 + 4;
			seg_left = 0;
			for (int k = 0; k < phase_len; k++) begin
				if (k < fill_len) begin
					alloc_pct = 90;
				end else if (seg_left == 0) begin
					seg_left = $urandom_range(8, 40);
					case ($urandom_range(0, 2))
						0:       alloc_pct = 15;
						1:       alloc_pct = 50;
						default: alloc_pct = 85;
					endcase
				end else begin
					seg_left--;
				end

				pick = $urandom_range(0, 99);
				if (pick < alloc_pct) begin
					mode = bhal_pkg::MODE_ALLOC;
				end else begin
					pick = $urandom_range(0, 99);
					if (pick < 45) begin
						mode = bhal_pkg::MODE_LOOKUP;
					end else if (pick < 95) begin
						mode = bhal_pkg::MODE_RELEASE;
					end else begin
						mode = bhal_pkg::MODE_NOP;
					end
				end

				// aim mostly inside the live range; the rest spans every handle value
				if (lim > 0 && $urandom_range(0, 9) != 0) begin
					h = HW'($urandom_range(0, lim - 1));
				end else begin
					h = HW'($urandom_range(0, 255));
				end
				case ($urandom_range(0, 9))
					0:       w = '0;
					1:       w = '1;
					default: w = $urandom;
				endcase

				if ($urandom_range(0, 29) == 0) begin
					src_burst = !src_burst;
				end
				// hold off now and then until the result side has caught up
				if ($urandom_range(0, 49) == 0) begin
					drain();
				end
				put_request(mode, h, w);
			end
		end

		drain();
		repeat (20) @(negedge clk);

		$display("covered %0d request words over %0d handle_limit settings (0 to 511)",
			words_sent, limits_written);
		$display("answers seen: %0d no free handle, %0d out of range, %0d not in use",
			full_seen, range_seen, idle_seen);
		if (fail_count == 0 && outstanding == 0) begin
			$display("bitmap_handle_allocator_core test passed");
		end else begin
			$display("bitmap_handle_allocator_core test failed");
		end
		$finish;
	end

endmodule
